FILE: design/iphpf_pkg.sv
// Package for the IPv4 header parse filter: request types, header offsets,
// protocol codes and register map constants. No dependencies.
`default_nettype none

package iphpf_pkg;

  // Per-byte input request
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_req_t;

  // Per-frame result request
  typedef struct packed {
    logic        verdict;
    logic        record_valid;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  proto;
    logic [15:0] src_port_out;
    logic [15:0] dst_port_out;
    logic [5:0]  flag_bits;
    logic [15:0] payload_length;
  } out_req_t;

  // Byte counter
  localparam int unsigned CntW = 6;
  localparam logic [CntW-1:0] CountMax = 6'd63;
  localparam int unsigned LenW = CntW + 1;

  // Frame offsets of captured fields
  localparam logic [CntW-1:0] OffEtherHi = 6'd12;
  localparam logic [CntW-1:0] OffEtherLo = 6'd13;
  localparam logic [CntW-1:0] OffIhl     = 6'd14;
  localparam logic [CntW-1:0] OffTlenHi  = 6'd16;
  localparam logic [CntW-1:0] OffTlenLo  = 6'd17;
  localparam logic [CntW-1:0] OffProto   = 6'd23;
  localparam logic [CntW-1:0] OffSrc0    = 6'd26;
  localparam logic [CntW-1:0] OffSrc3    = 6'd29;
  localparam logic [CntW-1:0] OffDst0    = 6'd30;
  localparam logic [CntW-1:0] OffDst3    = 6'd33;
  localparam logic [CntW-1:0] OffSportHi = 6'd34;
  localparam logic [CntW-1:0] OffSportLo = 6'd35;
  localparam logic [CntW-1:0] OffDportHi = 6'd36;
  localparam logic [CntW-1:0] OffDportLo = 6'd37;
  localparam logic [CntW-1:0] OffFlags   = 6'd47;

  // Minimum frame lengths
  localparam logic [LenW-1:0] MinLenIpv4 = 7'd34;
  localparam logic [LenW-1:0] MinLenUdp  = 7'd42;
  localparam logic [LenW-1:0] MinLenTcp  = 7'd54;

  // Header codes
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoIcmp     = 8'd1;
  localparam logic [7:0]  ProtoTcp      = 8'd6;
  localparam logic [7:0]  ProtoUdp      = 8'd17;

  // TCP flag masks
  localparam logic [5:0] FlagFin = 6'h01;
  localparam logic [5:0] FlagSyn = 6'h02;
  localparam logic [5:0] FlagRst = 6'h04;
  localparam logic [5:0] FlagPsh = 6'h08;
  localparam logic [5:0] FlagAck = 6'h10;
  localparam logic [5:0] FlagUrg = 6'h20;

  // Register map
  localparam int unsigned PaddrW = 3;
  localparam logic [PaddrW-1:0] AddrBlockedIcmpDest = 3'd0;
  localparam logic [31:0] BlockedIcmpDestReset = 32'h9DF0_0101;

endpackage

`default_nettype wire

FILE: design/iphpf_hdr_capture.sv
// Header capture and verdict logic: holds the per-frame captured fields and
// forms the frame result on the last byte. Depends on iphpf_pkg.
`default_nettype none

module iphpf_hdr_capture (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  iphpf_pkg::in_req_t    byte_i,
  input  wire logic [31:0]      blocked_dest_i,
  output iphpf_pkg::out_req_t   result_o
);
  import iphpf_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0] etype_q, etype_d;
  logic [3:0]  hwords_q, hwords_d;
  logic [15:0] tlen_q, tlen_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] saddr_q, saddr_d;
  logic [31:0] daddr_q, daddr_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;
  logic [5:0]  flags_q, flags_d;

  logic [7:0]      b;
  logic [LenW-1:0] len;
  logic            drop;
  logic            rec;
  logic            ports_ok;
  logic            flags_ok;

  assign b = byte_i.frame_byte;

  // Field capture at the current byte offset (values include this byte)
  always_comb begin
    etype_d  = etype_q;
    hwords_d = hwords_q;
    tlen_d   = tlen_q;
    proto_d  = proto_q;
    saddr_d  = saddr_q;
    daddr_d  = daddr_q;
    sport_d  = sport_q;
    dport_d  = dport_q;
    flags_d  = flags_q;
    case (cnt_q) inside
      OffEtherHi, OffEtherLo: etype_d  = {etype_q[7:0], b};
      OffIhl:                 hwords_d = b[3:0];
      OffTlenHi, OffTlenLo:   tlen_d   = {tlen_q[7:0], b};
      OffProto:               proto_d  = b;
      [OffSrc0:OffSrc3]:      saddr_d  = {saddr_q[23:0], b};
      [OffDst0:OffDst3]:      daddr_d  = {daddr_q[23:0], b};
      OffSportHi, OffSportLo: sport_d  = {sport_q[7:0], b};
      OffDportHi, OffDportLo: dport_d  = {dport_q[7:0], b};
      OffFlags:               flags_d  = b[5:0];
      default: ;
    endcase
  end

  // Saturating offset counter
  assign cnt_d = (cnt_q == CountMax) ? CountMax : cnt_q + 1'b1;
  assign len   = {1'b0, cnt_q} + 1'b1;

  // Verdict on the captured fields
  always_comb begin
    drop     = 1'b0;
    rec      = 1'b0;
    ports_ok = 1'b0;
    flags_ok = 1'b0;
    if (len >= MinLenIpv4 && etype_d == EtherTypeIpv4) begin
      if (proto_d == ProtoTcp) begin
        if (len >= MinLenTcp) begin
          if ((flags_d & (FlagSyn | FlagRst)) == (FlagSyn | FlagRst)) begin
            drop = 1'b1;
          end else begin
            rec      = 1'b1;
            ports_ok = 1'b1;
            flags_ok = 1'b1;
          end
        end
      end else if (proto_d == ProtoUdp) begin
        if (len >= MinLenUdp) begin
          rec      = 1'b1;
          ports_ok = 1'b1;
        end
      end else if (proto_d == ProtoIcmp && daddr_d == blocked_dest_i) begin
        drop = 1'b1;
      end else begin
        rec = 1'b1;
      end
    end
  end

  // Result fields; all zero when no record is reported
  always_comb begin
    result_o                = '0;
    result_o.verdict        = drop;
    result_o.record_valid   = rec;
    if (rec) begin
      result_o.src_addr       = saddr_d;
      result_o.dst_addr       = daddr_d;
      result_o.proto          = proto_d;
      result_o.src_port_out   = ports_ok ? sport_d : 16'd0;
      result_o.dst_port_out   = ports_ok ? dport_d : 16'd0;
      result_o.flag_bits      = flags_ok ? flags_d : 6'd0;
      result_o.payload_length = tlen_d - {10'd0, hwords_d, 2'b00};
    end
  end

  // Frame state: cleared after the last byte of every frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      etype_q  <= '0;
      hwords_q <= '0;
      tlen_q   <= '0;
      proto_q  <= '0;
      saddr_q  <= '0;
      daddr_q  <= '0;
      sport_q  <= '0;
      dport_q  <= '0;
      flags_q  <= '0;
    end else if (fire_i) begin
      if (byte_i.frame_end) begin
        cnt_q    <= '0;
        etype_q  <= '0;
        hwords_q <= '0;
        tlen_q   <= '0;
        proto_q  <= '0;
        saddr_q  <= '0;
        daddr_q  <= '0;
        sport_q  <= '0;
        dport_q  <= '0;
        flags_q  <= '0;
      end else begin
        cnt_q    <= cnt_d;
        etype_q  <= etype_d;
        hwords_q <= hwords_d;
        tlen_q   <= tlen_d;
        proto_q  <= proto_d;
        saddr_q  <= saddr_d;
        daddr_q  <= daddr_d;
        sport_q  <= sport_d;
        dport_q  <= dport_d;
        flags_q  <= flags_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/ipv4_header_parse_filter_core.sv
// IPv4 header parse filter top level: input register, header capture, result
// register and APB register port. Depends on iphpf_pkg and iphpf_hdr_capture.
// Path: a frame's last byte passes the input register, then the result register.
// Throughput: one byte per cycle; only a stalled pending result holds up a
// following frame-end byte in the input register.
// Reset: frame state and handshakes clear; blocked_icmp_dest returns to
// 0x9DF00101.
`default_nettype none

module ipv4_header_parse_filter_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // byte channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  iphpf_pkg::in_req_t                 in_req_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output iphpf_pkg::out_req_t                out_req_o,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [iphpf_pkg::PaddrW-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import iphpf_pkg::*;

  logic      s1_valid_q;
  in_req_t   s1_q;
  logic      s1_move;
  logic      in_take;

  logic      out_valid_q;
  out_req_t  out_q;
  out_req_t  result;

  logic [31:0] blocked_q;
  logic        reg_sel;

  // Register port: single register, word index in paddr[2]
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == AddrBlockedIcmpDest[2]);
  assign prdata  = reg_sel ? blocked_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_q <= BlockedIcmpDestReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      blocked_q <= pwdata;
    end
  end

  // Stage handshake: a frame-end byte waits while a result is still stalled
  assign s1_move    = s1_valid_q && !(s1_q.frame_end && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_req_i;
    end
  end

  iphpf_hdr_capture u_capture (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (s1_move),
    .byte_i         (s1_q),
    .blocked_dest_i (blocked_q),
    .result_o       (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move && s1_q.frame_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_q.frame_end) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

`default_nettype wire
